// ===== src/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int QBITS     = DATA_W;
  localparam int REM_W     = MAG_W + QBITS;
  localparam int NSTG      = 3 + QBITS + 1;
  localparam int IN_W      = 136;
  localparam int OUT_W     = 2 * DATA_W;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_ri;
    logic [PROD_W-1:0]        d_r;
    logic [PROD_W-1:0]        d_i;
  } mul_t;

  typedef struct packed {
    op_t                     op;
    logic signed [SUM_W-1:0] v_re;
    logic signed [SUM_W-1:0] v_im;
    logic [MAG_W-1:0]        den;
  } sum_t;

  typedef struct packed {
    op_t               op;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
    logic [MAG_W-1:0]  den;
    logic [DATA_W-1:0] pre_re;
    logic [DATA_W-1:0] pre_im;
    logic              pre_ov;
  } div_t;

  // {overflow, value} of a signed wide value clamped to DATA_W bits
  function automatic logic [DATA_W:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic ov;
    ov = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
    if (ov) begin
      return {1'b1, (v[SUM_W-1] ? SAT_MIN : SAT_MAX)};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  // {overflow, value} of a sign/magnitude quotient; big means q >= 2^QBITS
  function automatic logic [DATA_W:0] sat_q(input logic neg, input logic big,
                                            input logic [QBITS-1:0] q);
    logic ov;
    if (!neg) begin
      ov = big | q[QBITS-1];
      return {ov, (ov ? SAT_MAX : DATA_W'(q))};
    end
    ov = big | (q[QBITS-1] & (|q[QBITS-2:0]));
    return {ov, (ov ? SAT_MIN : DATA_W'(0 - q))};
  endfunction

endpackage

// ===== src/cau_mul.sv =====
// First stage: the six 32x32 operand products.
module cau_mul (
  input  logic                          clk,
  input  logic                          en,
  input  cau_pkg::op_t                  op,
  input  logic signed [cau_pkg::DATA_W-1:0] a_re,
  input  logic signed [cau_pkg::DATA_W-1:0] a_im,
  input  logic signed [cau_pkg::DATA_W-1:0] b_re,
  input  logic signed [cau_pkg::DATA_W-1:0] b_im,
  output cau_pkg::mul_t                 dout
);
  import cau_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.op   <= op;
      dout.a_re <= a_re;
      dout.a_im <= a_im;
      dout.b_re <= b_re;
      dout.b_im <= b_im;
      dout.p_rr <= a_re * b_re;
      dout.p_ii <= a_im * b_im;
      dout.p_ir <= a_im * b_re;
      dout.p_ri <= a_re * b_im;
      dout.d_r  <= b_re * b_re;
      dout.d_i  <= b_im * b_im;
    end
  end

endmodule

// ===== src/cau_sum.sv =====
// Stages two and three: product sums, add/sub/mul results, divider setup.
module cau_sum (
  input  logic              clk,
  input  logic [1:0]        en,
  input  cau_pkg::mul_t     din,
  output cau_pkg::div_t     dout
);
  import cau_pkg::*;

  sum_t s2_next;
  sum_t s2;
  div_t s3_next;

  logic signed [SUM_W-1:0] sc_re, sc_im;
  logic [DATA_W:0]         sr_re, sr_im;
  logic [SUM_W-1:0]        abs_re, abs_im;
  logic [REM_W-1:0]        n_re, n_im;

  // sums of operands or of products, chosen by operation
  always_comb begin
    s2_next.op  = din.op;
    s2_next.den = din.d_r + din.d_i;
    case (din.op)
      OP_ADD: begin
        s2_next.v_re = SUM_W'(din.a_re) + SUM_W'(din.b_re);
        s2_next.v_im = SUM_W'(din.a_im) + SUM_W'(din.b_im);
      end
      OP_SUB: begin
        s2_next.v_re = SUM_W'(din.a_re) - SUM_W'(din.b_re);
        s2_next.v_im = SUM_W'(din.a_im) - SUM_W'(din.b_im);
      end
      OP_MUL: begin
        s2_next.v_re = SUM_W'(din.p_rr) - SUM_W'(din.p_ii);
        s2_next.v_im = SUM_W'(din.p_ir) + SUM_W'(din.p_ri);
      end
      default: begin
        s2_next.v_re = SUM_W'(din.p_rr) + SUM_W'(din.p_ii);
        s2_next.v_im = SUM_W'(din.p_ir) - SUM_W'(din.p_ri);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s2 <= s2_next;
    end
  end

  // multiply scales by floor; add/sub pass unscaled
  always_comb begin
    sc_re  = (s2.op == OP_MUL) ? (s2.v_re >>> FRAC_BITS) : s2.v_re;
    sc_im  = (s2.op == OP_MUL) ? (s2.v_im >>> FRAC_BITS) : s2.v_im;
    sr_re  = sat_val(sc_re);
    sr_im  = sat_val(sc_im);
    abs_re = s2.v_re[SUM_W-1] ? SUM_W'(-s2.v_re) : SUM_W'(s2.v_re);
    abs_im = s2.v_im[SUM_W-1] ? SUM_W'(-s2.v_im) : SUM_W'(s2.v_im);
    n_re   = REM_W'(abs_re[MAG_W-1:0]) << FRAC_BITS;
    n_im   = REM_W'(abs_im[MAG_W-1:0]) << FRAC_BITS;

    s3_next.op     = s2.op;
    s3_next.dz     = (s2.den == '0);
    s3_next.neg_re = s2.v_re[SUM_W-1];
    s3_next.neg_im = s2.v_im[SUM_W-1];
    s3_next.big_re = (n_re >> QBITS) >= REM_W'(s2.den);
    s3_next.big_im = (n_im >> QBITS) >= REM_W'(s2.den);
    s3_next.rem_re = n_re;
    s3_next.rem_im = n_im;
    s3_next.q_re   = '0;
    s3_next.q_im   = '0;
    s3_next.den    = s2.den;
    s3_next.pre_re = sr_re[DATA_W-1:0];
    s3_next.pre_im = sr_im[DATA_W-1:0];
    s3_next.pre_ov = sr_re[DATA_W] | sr_im[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= s3_next;
    end
  end

endmodule

// ===== src/cau_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, both parts in parallel.
module cau_div (
  input  logic                        clk,
  input  logic [cau_pkg::QBITS-1:0]   en,
  input  cau_pkg::div_t               din,
  output cau_pkg::div_t               dout
);
  import cau_pkg::*;

  div_t stg_in [QBITS];
  div_t stg    [QBITS];

  assign stg_in[0] = din;
  assign dout      = stg[QBITS-1];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    localparam int BIT = QBITS - 1 - k;
    logic [REM_W-1:0] dsh;
    logic             ge_re, ge_im;
    div_t             stg_next;

    if (k > 0) begin : g_link
      assign stg_in[k] = stg[k-1];
    end

    assign dsh   = REM_W'(stg_in[k].den) << BIT;
    assign ge_re = stg_in[k].rem_re >= dsh;
    assign ge_im = stg_in[k].rem_im >= dsh;

    always_comb begin
      stg_next = stg_in[k];
      if (ge_re) begin
        stg_next.rem_re = stg_in[k].rem_re - dsh;
      end
      if (ge_im) begin
        stg_next.rem_im = stg_in[k].rem_im - dsh;
      end
      stg_next.q_re[BIT] = ge_re;
      stg_next.q_im[BIT] = ge_im;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg[k] <= stg_next;
      end
    end
  end

endmodule

// ===== src/cau_out.sv =====
// Last stage: result select, quotient saturation, zero-divisor handling, output register.
module cau_out (
  input  logic                             clk,
  input  logic                             en,
  input  cau_pkg::div_t                    din,
  output logic [cau_pkg::DATA_W-1:0]       res_re,
  output logic [cau_pkg::DATA_W-1:0]       res_im,
  output logic                             overflow,
  output logic                             divide_by_zero
);
  import cau_pkg::*;

  logic [DATA_W:0]   qs_re, qs_im;
  logic [DATA_W-1:0] res_re_next, res_im_next;
  logic              ov_next, dz_next;

  always_comb begin
    qs_re = sat_q(din.neg_re, din.big_re, din.q_re);
    qs_im = sat_q(din.neg_im, din.big_im, din.q_im);
    if (din.op != OP_DIV) begin
      res_re_next = din.pre_re;
      res_im_next = din.pre_im;
      ov_next     = din.pre_ov;
      dz_next     = 1'b0;
    end else if (din.dz) begin
      res_re_next = '0;
      res_im_next = '0;
      ov_next     = 1'b0;
      dz_next     = 1'b1;
    end else begin
      res_re_next = qs_re[DATA_W-1:0];
      res_im_next = qs_im[DATA_W-1:0];
      ov_next     = qs_re[DATA_W] | qs_im[DATA_W];
      dz_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re         <= res_re_next;
      res_im         <= res_im_next;
      overflow       <= ov_next;
      divide_by_zero <= dz_next;
    end
  end

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Top level of the pipelined complex add/subtract/multiply/divide unit.
//
// Usage:
//   s_* carries one request: two complex Q16.16 operands and an operation
//   code (add, subtract, multiply, divide). m_* returns one result per
//   request, in order: both saturated parts in tdata, the overflow and
//   divide-by-zero flags in tuser.
// Pipeline: products, sums, setup, 32 restoring-divider bit stages,
//   saturation. Every operation takes the full pipe so results stay in order.
// Throughput: one request per cycle unless the pipe is full and stalled; every stage is fully pipelined.
// Stall: each stage holds while its successor is full and blocked; empty
//   stages keep filling, so requests are still taken while a result waits
//   until the pipe is full. s_tready drops only when it is.
// Reset: clears all stage valid bits; data registers are not reset.
// Divide of a zero divisor returns 0 + j0 with divide_by_zero set.
module complex_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // operation[1:0], a_re[33:2], a_im[65:34], b_re[97:66], b_im[129:98]
  input  logic [cau_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // res_re[31:0], res_im[63:32]
  output logic [cau_pkg::OUT_W-1:0]   m_tdata,
  // overflow[0], divide_by_zero[1]
  output logic [1:0]                  m_tuser
);
  import cau_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  mul_t mul_q;
  div_t setup_q;
  div_t div_q;

  logic [DATA_W-1:0] res_re, res_im;
  logic              overflow, divide_by_zero;

  // a stage may load when it is empty or its content moves on
  assign en[NSTG-1] = !vld[NSTG-1] || m_tready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTG-1];

  cau_mul u_mul (
    .clk  (clk),
    .en   (en[0]),
    .op   (op_t'(s_tdata[1:0])),
    .a_re (s_tdata[33:2]),
    .a_im (s_tdata[65:34]),
    .b_re (s_tdata[97:66]),
    .b_im (s_tdata[129:98]),
    .dout (mul_q)
  );

  cau_sum u_sum (
    .clk  (clk),
    .en   (en[2:1]),
    .din  (mul_q),
    .dout (setup_q)
  );

  cau_div u_div (
    .clk  (clk),
    .en   (en[NSTG-2:3]),
    .din  (setup_q),
    .dout (div_q)
  );

  cau_out u_out (
    .clk            (clk),
    .en             (en[NSTG-1]),
    .din            (div_q),
    .res_re         (res_re),
    .res_im         (res_im),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  assign m_tdata = {res_im, res_re};
  assign m_tuser = {divide_by_zero, overflow};

  // zero divisor gives a clean zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && divide_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
    else $error("divide by zero result not clean");

  // a saturated result sits at a limit
  a_ov_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && overflow |-> res_re == SAT_MAX || res_re == SAT_MIN ||
                             res_im == SAT_MAX || res_im == SAT_MIN)
    else $error("overflow without saturated part");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with free output");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the complex arithmetic unit.
`timescale 1ns / 1ps

module testbench;
  import cau_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic [1:0]          m_tuser;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ov;
    logic        dz;
  } cplx_res_t;

  cplx_res_t   pending_results[$];
  int          mismatch_count = 0;
  int          request_count = 0;
  int          result_count = 0;
  int          op_count[4] = '{0, 0, 0, 0};
  int          ov_seen = 0;
  int          dz_seen = 0;
  bit          stall_en = 1'b1;

  complex_arithmetic_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a sign/magnitude value to 32-bit two's complement.
  function automatic logic [32:0] clamp_sm(input logic neg, input logic [127:0] mag);
    if (!neg) begin
      if (mag > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, mag[31:0]};
    end
    if (mag > 128'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, 32'(0 - mag[31:0])};
  endfunction

  // Expected result of one request.
  function automatic cplx_res_t complex_result(input op_t op,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    cplx_res_t r;
    logic signed [127:0] n_re, n_im, den;
    logic [127:0] m;
    logic [32:0] c_re, c_im;
    r = '0;
    n_re = 0;
    n_im = 0;
    den = 0;
    case (op)
      OP_ADD: begin
        n_re = 128'(ar) + 128'(br);
        n_im = 128'(ai) + 128'(bi);
      end
      OP_SUB: begin
        n_re = 128'(ar) - 128'(br);
        n_im = 128'(ai) - 128'(bi);
      end
      OP_MUL: begin
        // arithmetic shift gives floor rounding
        n_re = (128'(ar) * 128'(br) - 128'(ai) * 128'(bi)) >>> FRAC_BITS;
        n_im = (128'(ai) * 128'(br) + 128'(ar) * 128'(bi)) >>> FRAC_BITS;
      end
      default: begin
        den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        n_re = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
        n_im = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
      end
    endcase
    if (op != OP_DIV) begin
      m = n_re[127] ? 0 - n_re : n_re;
      c_re = clamp_sm(n_re[127], m);
      m = n_im[127] ? 0 - n_im : n_im;
      c_im = clamp_sm(n_im[127], m);
    end else if (den == 0) begin
      r.dz = 1'b1;
      return r;
    end else begin
      // quotient magnitude truncated toward zero
      m = ((n_re[127] ? 0 - n_re : n_re) << FRAC_BITS) / den;
      c_re = clamp_sm(n_re[127] && m != 0, m);
      m = ((n_im[127] ? 0 - n_im : n_im) << FRAC_BITS) / den;
      c_im = clamp_sm(n_im[127] && m != 0, m);
    end
    r.re = c_re[31:0];
    r.im = c_im[31:0];
    r.ov = c_re[32] | c_im[32];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch #%0d on %s: got %h want %h (result %0d)",
             mismatch_count, what, got, want, result_count);
  endtask

  // Sends one request; waits for accept. Valid stays high into the next call.
  task automatic send_request(input op_t op, input logic [31:0] ar,
      input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({bi, br, ai, ar, op});
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(complex_result(op, ar, ai, br, bi));
    request_count++;
    op_count[op]++;
  endtask

  // A zero-length gap leaves valid high for the next request.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Receiver stalls: ready drops at random with probability 64/256, and stays high while bit 7 of request_count is set.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (!stall_en) m_tready <= 1'b1;
    else m_tready <= (($urandom_range(0, 255) < 64) ? 1'b0 : 1'b1) | (request_count[7]);
  end

  // Result checker
  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.re)
          report_mismatch("res_re", m_tdata[31:0], want.re);
        if (m_tdata[63:32] !== want.im)
          report_mismatch("res_im", m_tdata[63:32], want.im);
        if (m_tuser[0] !== want.ov)
          report_mismatch("overflow", 32'(m_tuser[0]), 32'(want.ov));
        if (m_tuser[1] !== want.dz)
          report_mismatch("divide_by_zero", 32'(m_tuser[1]), 32'(want.dz));
        ov_seen += want.ov;
        dz_seen += want.dz;
      end
    end
  end

  // Operand with bias toward edge values and small Q16.16 numbers.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC_BITS;
      4, 5: return 32'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] edges[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000,
                              32'hFFFF_FFFF, 32'h0000_0001};
    for (int o = 0; o < 4; o++) begin
      send_request(op_t'(o), edges[0], edges[1], edges[0], edges[1]);
      send_request(op_t'(o), edges[1], edges[1], edges[1], edges[1]);
      send_request(op_t'(o), edges[0], edges[0], edges[0], edges[0]);
      send_request(op_t'(o), edges[3], edges[4], edges[5], edges[3]);
    end
    // zero divisor, tiny divisor, exact and rounding cases
    send_request(OP_DIV, edges[1], edges[0], 32'h0, 32'h0);
    send_request(OP_DIV, edges[3], edges[3], edges[5], 32'h0);
    send_request(OP_DIV, edges[4], 32'h0, 32'h0003_0000, 32'h0);
    send_request(OP_MUL, edges[4], 32'h0, edges[5], 32'h0);
    send_request(OP_MUL, edges[0], edges[0], edges[0], edges[3]);
    idle_cycles(1);
  endtask

  task automatic test_random(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--)
        send_request(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                     pick_operand(), pick_operand());
      idle_cycles($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6));
    end
  endtask

  task automatic test_full_rate(input int n);
    stall_en = 1'b0;
    for (int i = 0; i < n; i++)
      send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
    idle_cycles(1);
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(800);
    test_full_rate(100);
    test_random(100);
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d requests (add %0d, sub %0d, mul %0d, div %0d), %0d results",
             request_count, op_count[0], op_count[1], op_count[2], op_count[3],
             result_count);
    $display("saturated results %0d, zero divisors %0d", ov_seen, dz_seen);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cau_pkg.sv
src/cau_mul.sv
src/cau_sum.sv
src/cau_div.sv
src/cau_out.sv
src/complex_arithmetic_unit.sv
sim/testbench.sv
